FILE: sv/sfc_pkg.sv
// Shared types, codes and the CRC byte update for the serial frame CRC-16 block.
// No dependencies; every other file in sv/ imports this package.
package sfc_pkg;

  localparam logic [7:0]  HDR_BYTE = 8'hA5;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] CFG_SEND_MODE    = 2'd1;
  localparam logic [1:0] CFG_CRC_SEED     = 2'd2;

  localparam logic [7:0]  FRAME_LENGTH_RST = 8'd16;
  localparam logic [7:0]  FRAME_LENGTH_MIN = 8'd3;
  localparam logic [15:0] CRC_SEED_RST     = 16'hFFFF;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BAD   = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_status;
    status_t     frame_status;
    logic [15:0] crc_value;
    logic        last;
  } result_t;

  // One accepted item as seen by the output stage
  typedef struct packed {
    logic    load;    // item yields at least one result
    logic    triple;  // follow the result with the CRC low and high bytes
    result_t res;
  } push_t;

  // Reflected CRC-16 update by one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/sfc_item_if.sv
// Input channel: one frame or payload byte per transaction.
// Depends on sfc_pkg.
interface sfc_item_if;
  import sfc_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

FILE: sv/sfc_result_if.sv
// Output channel: one transmit byte or one frame status per transaction.
// Depends on sfc_pkg.
interface sfc_result_if;
  import sfc_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_status;
  status_t     frame_status;
  logic [15:0] crc_value;
  logic        last;

  modport source (output valid, output out_byte, output is_status, output frame_status,
                  output crc_value, output last, input ready);
  modport sink   (input valid, input out_byte, input is_status, input frame_status,
                  input crc_value, input last, output ready);
endinterface

FILE: sv/sfc_out_stage.sv
// Result register with a two-entry tail sequencer for the appended CRC bytes.
// Depends on sfc_pkg.
module sfc_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_en,
  input  sfc_pkg::push_t  push,
  output logic            can_load,
  output logic            res_valid,
  input  logic            res_ready,
  output sfc_pkg::result_t res
);
  import sfc_pkg::*;

  logic        vld, vld_next;
  result_t     data, data_next;
  logic [1:0]  tail_cnt, tail_cnt_next;
  logic [15:0] tail_crc, tail_crc_next;
  logic        take;

  assign take      = vld && res_ready;
  assign can_load  = !vld || (take && (tail_cnt == 2'd0));
  assign res_valid = vld;
  assign res       = data;

  always_comb begin
    vld_next      = vld;
    data_next     = data;
    tail_cnt_next = tail_cnt;
    tail_crc_next = tail_crc;
    if (take && (tail_cnt != 2'd0)) begin
      // advance through the CRC bytes, low first
      data_next.is_status    = 1'b0;
      data_next.frame_status = STATUS_OK;
      data_next.crc_value    = tail_crc;
      if (tail_cnt == 2'd2) begin
        data_next.out_byte = tail_crc[7:0];
        data_next.last     = 1'b0;
      end else begin
        data_next.out_byte = tail_crc[15:8];
        data_next.last     = 1'b1;
      end
      tail_cnt_next = tail_cnt - 2'd1;
    end else if (can_load) begin
      vld_next = push_en && push.load;
      if (push_en && push.load) begin
        data_next     = push.res;
        tail_cnt_next = push.triple ? 2'd2 : 2'd0;
        tail_crc_next = push.res.crc_value;
        if (push.triple) begin
          data_next.crc_value = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= 1'b0;
      tail_cnt <= 2'd0;
    end else begin
      vld      <= vld_next;
      tail_cnt <= tail_cnt_next;
    end
    data     <= data_next;
    tail_crc <= tail_crc_next;
  end

endmodule

FILE: sv/serial_frame_crc16_check_append_core.sv
// Serial frame CRC-16 (reflected, poly 0x8408) checker and appender, top level.
// Depends on sfc_pkg, sfc_item_if, sfc_result_if and sfc_out_stage.
//
//   channel   | kind             | payload
//   ----------+------------------+-------------------------------------------------
//   item      | valid/ready sink | data_byte[7:0], frame_end
//   result    | valid/ready src  | out_byte[7:0], is_status, frame_status[1:0],
//             |                  | crc_value[15:0], last
//   cfg       | write only       | cfg_wr_en, cfg_index[1:0], cfg_data[15:0]
//
// Each byte is processed in the cycle it is accepted: one CRC byte update and the
// frame compare sit between the item handshake and the result register, so one
// byte per cycle is taken while the result side keeps up.
// The last payload byte in append mode yields three results; the result register
// then holds item.ready low while the CRC low and high bytes go out.
// A stalled result holds item.ready low. Bytes that yield no result (check mode,
// mid-frame) still wait for the result register to be free.
// Reset (rst, synchronous) restores frame_length 16, send_mode 0, crc_seed 0xFFFF
// and clears the frame state. Any configuration write aborts the frame in progress.
module serial_frame_crc16_check_append_core (
  input  logic         clk,
  input  logic         rst,
  sfc_item_if.sink     item,
  sfc_result_if.source result,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import sfc_pkg::*;

  // configuration registers
  logic [7:0]  frame_length;
  logic        send_mode;
  logic [15:0] crc_seed;

  // frame state
  logic [15:0] crc_running, crc_running_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        header_bad, header_bad_next;
  logic        low_crc_match, low_crc_match_next;

  logic        accept;
  logic        can_load;
  push_t       push;
  result_t     res;
  logic [7:0]  len;
  logic [7:0]  tx_byte;
  logic [15:0] crc_upd;
  logic        full_match;
  logic        restart;

  assign accept = item.valid && item.ready;
  assign item.ready = can_load;

  // lengths below three act as three
  assign len = (frame_length < FRAME_LENGTH_MIN) ? FRAME_LENGTH_MIN : frame_length;

  // in append mode the first byte is forced to the header
  assign tx_byte = (send_mode && (byte_count == 8'd0)) ? HDR_BYTE : item.data_byte;
  assign crc_upd = crc_byte(crc_running, tx_byte);

  always_comb begin
    crc_running_next   = crc_running;
    byte_count_next    = byte_count;
    header_bad_next    = header_bad;
    low_crc_match_next = low_crc_match;
    full_match         = 1'b0;
    restart            = 1'b0;
    push               = '0;

    if (send_mode) begin
      push.load             = 1'b1;
      push.res.out_byte     = tx_byte;
      push.res.frame_status = STATUS_OK;
      crc_running_next      = crc_upd;
      if (byte_count >= len - 8'd3) begin
        // last payload byte: queue the CRC bytes behind it
        push.triple        = 1'b1;
        push.res.crc_value = crc_upd;
        restart            = 1'b1;
      end else begin
        byte_count_next = byte_count + 8'd1;
      end
    end else begin
      if (byte_count == 8'd0) begin
        header_bad_next = (item.data_byte != HDR_BYTE);
      end
      if (byte_count < len - 8'd2) begin
        crc_running_next = crc_upd;
      end else if (byte_count == len - 8'd2) begin
        low_crc_match_next = (item.data_byte == crc_running[7:0]);
      end else begin
        full_match = low_crc_match && (item.data_byte == crc_running[15:8]);
      end

      push.res.is_status = 1'b1;
      push.res.last      = 1'b1;
      push.res.crc_value = crc_running_next;
      if (byte_count >= len - 8'd1) begin
        // full length reached: end marker does not matter here
        push.load             = 1'b1;
        push.res.frame_status = (!header_bad_next && full_match) ? STATUS_OK : STATUS_BAD;
        restart               = 1'b1;
      end else if (item.frame_end) begin
        push.load             = 1'b1;
        push.res.frame_status = STATUS_SHORT;
        restart               = 1'b1;
      end else begin
        push.res.frame_status = STATUS_OK;
        byte_count_next       = byte_count + 8'd1;
      end
    end

    if (restart) begin
      crc_running_next   = crc_seed;
      byte_count_next    = 8'd0;
      header_bad_next    = 1'b0;
      low_crc_match_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= FRAME_LENGTH_RST;
      send_mode     <= 1'b0;
      crc_seed      <= CRC_SEED_RST;
      crc_running   <= CRC_SEED_RST;
      byte_count    <= 8'd0;
      header_bad    <= 1'b0;
      low_crc_match <= 1'b0;
    end else if (cfg_wr_en) begin
      // any write, even to an unused index, drops the frame in progress
      case (cfg_index)
        CFG_FRAME_LENGTH: frame_length <= cfg_data[7:0];
        CFG_SEND_MODE:    send_mode    <= cfg_data[0];
        CFG_CRC_SEED:     crc_seed     <= cfg_data;
        default:          ;
      endcase
      // reload from the seed as it stands after this write
      crc_running   <= (cfg_index == CFG_CRC_SEED) ? cfg_data : crc_seed;
      byte_count    <= 8'd0;
      header_bad    <= 1'b0;
      low_crc_match <= 1'b0;
    end else if (accept) begin
      crc_running   <= crc_running_next;
      byte_count    <= byte_count_next;
      header_bad    <= header_bad_next;
      low_crc_match <= low_crc_match_next;
    end
  end

  sfc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push_en   (accept),
    .push      (push),
    .can_load  (can_load),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res       (res)
  );

  assign result.out_byte     = res.out_byte;
  assign result.is_status    = res.is_status;
  assign result.frame_status = res.frame_status;
  assign result.crc_value    = res.crc_value;
  assign result.last         = res.last;

endmodule

FILE: sv/sfc_checker.sv
// Port-level assertions for the serial frame CRC-16 core, bound to the top level.
// Depends on sfc_pkg and serial_frame_crc16_check_append_core.
module sfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [7:0]  out_byte,
  input logic        is_status,
  input logic [1:0]  frame_status,
  input logic [15:0] crc_value,
  input logic        last
);
  import sfc_pkg::*;

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_byte)
      && $stable(is_status) && $stable(frame_status) && $stable(crc_value) && $stable(last))
    else $error("stalled result changed");

  // no new byte is taken while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("item accepted while result stalled");

  // a status closes its frame and carries no byte
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_status |-> last && (out_byte == 8'd0))
    else $error("malformed status result");

  // transmit bytes carry an ok status
  a_tx_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_status |-> (frame_status == STATUS_OK))
    else $error("transmit byte with status");

endmodule

bind serial_frame_crc16_check_append_core sfc_checker u_sfc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_byte     (result.out_byte),
  .is_status    (result.is_status),
  .frame_status (result.frame_status),
  .crc_value    (result.crc_value),
  .last         (result.last)
);

FILE: tb/tb_top.sv
// Self-checking testbench for serial_frame_crc16_check_append_core: CRC-16 frame
// check and CRC append, compared transaction by transaction against a local model.
// Depends on sfc_pkg, sfc_item_if, sfc_result_if and the core itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 250;
  localparam int IDLE_PCT     = 38;
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index with no register behind it

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  sfc_item_if   item_ch ();
  sfc_result_if res_ch ();

  serial_frame_crc16_check_append_core uut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Local copy of the block's registers and frame state
  logic [7:0]  cfg_len;
  logic        cfg_send;
  logic [15:0] cfg_seed;
  logic [15:0] crc_acc;
  logic [7:0]  frame_pos;
  logic        hdr_bad;
  logic        crc_lo_ok;

  // Results owed by the block, oldest first
  result_t due_outputs [$];

  int  n_fail;
  int  n_items;
  int  n_results;
  int  n_status;
  int  n_cfg_writes;
  int  cycles;
  int  hold_left;  // receiver holds ready low while this counts down
  bit  steady;     // no random idling on either side while set

  // Reflected CRC-16 over one byte, one bit at a time, LSB first
  function automatic logic [15:0] crc_advance(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    int   i;
    for (i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void owe_output(input logic [7:0] ob, input logic st,
                                     input status_t fs, input logic [15:0] cv,
                                     input logic lst);
    result_t r;
    r.out_byte     = ob;
    r.is_status    = st;
    r.frame_status = fs;
    r.crc_value    = cv;
    r.last         = lst;
    due_outputs.push_back(r);
  endfunction

  function automatic void restart_frame();
    crc_acc   = cfg_seed;
    frame_pos = 8'd0;
    hdr_bad   = 1'b0;
    crc_lo_ok = 1'b0;
  endfunction

  // Work out what one accepted byte produces and advance the frame state
  function automatic void advance_frame_state(input logic [7:0] b, input logic fend);
    int         eff_len;
    logic [7:0] tx;
    logic       crc_full_ok;
    eff_len = int'((cfg_len < FRAME_LENGTH_MIN) ? FRAME_LENGTH_MIN : cfg_len);
    if (cfg_send) begin
      // Append: first byte is forced to the header, CRC follows the last payload byte
      tx      = (frame_pos == 0) ? HDR_BYTE : b;
      crc_acc = crc_advance(crc_acc, tx);
      owe_output(tx, 1'b0, STATUS_OK, 16'h0000, 1'b0);
      if (int'(frame_pos) >= eff_len - 3) begin
        owe_output(crc_acc[7:0], 1'b0, STATUS_OK, crc_acc, 1'b0);
        owe_output(crc_acc[15:8], 1'b0, STATUS_OK, crc_acc, 1'b1);
        restart_frame();
      end else begin
        frame_pos++;
      end
    end else begin
      crc_full_ok = 1'b0;
      if (frame_pos == 0) hdr_bad = (b != HDR_BYTE);
      if (int'(frame_pos) < eff_len - 2)
        crc_acc = crc_advance(crc_acc, b);
      else if (int'(frame_pos) == eff_len - 2)
        crc_lo_ok = (b == crc_acc[7:0]);
      else
        crc_full_ok = crc_lo_ok && (b == crc_acc[15:8]);

      if (int'(frame_pos) + 1 >= eff_len) begin
        // Full length wins over the end marker; header and CRC errors merge
        owe_output(8'h00, 1'b1, (!hdr_bad && crc_full_ok) ? STATUS_OK : STATUS_BAD,
                   crc_acc, 1'b1);
        restart_frame();
      end else if (fend) begin
        owe_output(8'h00, 1'b1, STATUS_SHORT, crc_acc, 1'b1);
        restart_frame();
      end else begin
        frame_pos++;
      end
    end
  endfunction

  // Offer one byte, hold it until the handshake, then update the model
  task automatic send_byte(input logic [7:0] b, input logic fend);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.data_byte <= b;
    item_ch.frame_end <= fend;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    advance_frame_state(b, fend);
    n_items++;
  endtask

  // Register write, only with the block drained; any write aborts the frame
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    item_ch.valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_FRAME_LENGTH: cfg_len  = val[7:0];
      CFG_SEND_MODE:    cfg_send = val[0];
      CFG_CRC_SEED:     cfg_seed = val;
      default: ;
    endcase
    restart_frame();
    n_cfg_writes++;
  endtask

  // Check-mode frame of n bytes with a matching CRC trailer. Optionally spoil the
  // header, corrupt one byte (flip_at) or raise frame_end early (end_at, then stop).
  task automatic send_check_frame(input int n, input bit bad_hdr, input int flip_at,
                                  input int end_at);
    logic [7:0]  fr [$];
    logic [7:0]  v;
    logic [15:0] c;
    int          k;
    v = 8'($urandom_range(0, 255));
    if (v == HDR_BYTE) v = 8'h00;
    fr.push_back(bad_hdr ? v : HDR_BYTE);
    for (k = 1; k < n - 2; k++) fr.push_back(8'($urandom_range(0, 255)));
    c = cfg_seed;
    for (k = 0; k < fr.size(); k++) c = crc_advance(c, fr[k]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    if (flip_at >= 0) fr[flip_at] = fr[flip_at] ^ 8'($urandom_range(1, 255));
    for (k = 0; k < n; k++) begin
      if (k == end_at) begin
        send_byte(fr[k], 1'b1);
        break;
      end
      // The marker on the closing byte must not change the outcome
      send_byte(fr[k], (k == n - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
    end
  endtask

  task automatic send_payload(input int n);
    int k;
    for (k = 0; k < n; k++)
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: length 16, check mode, seed 0xFFFF. End the frame early so the
  // status carries the CRC grown from the reset seed.
  task automatic test_reset_defaults();
    send_byte(HDR_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Length 0 acts as 3. Cover ok, bad header, bad CRC high and low, early end on
  // the header byte, and the end marker on the byte that completes the frame.
  task automatic test_min_length_status();
    write_reg(CFG_FRAME_LENGTH, 16'd0);
    send_check_frame(3, 1'b0, -1, -1);
    send_check_frame(3, 1'b1, -1, -1);
    send_check_frame(3, 1'b0, 2, -1);
    send_check_frame(3, 1'b0, 1, -1);
    send_check_frame(3, 1'b0, -1, 0);
    write_reg(CFG_FRAME_LENGTH, 16'd2);
    send_check_frame(3, 1'b0, -1, 2);
  endtask

  task automatic test_seed_extremes();
    write_reg(CFG_CRC_SEED, 16'h0000);
    send_check_frame(3, 1'b0, -1, -1);
    write_reg(CFG_CRC_SEED, CRC_SEED_RST);
  endtask

  // Append mode at the two shortest lengths; the first byte is always replaced
  task automatic test_append_mode();
    write_reg(CFG_SEND_MODE, 16'd1);
    write_reg(CFG_FRAME_LENGTH, 16'd3);
    send_byte(8'h00, 1'b0);
    write_reg(CFG_FRAME_LENGTH, 16'd4);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // A write to the unused index still drops the partial frame
  task automatic test_config_abort();
    write_reg(CFG_SEND_MODE, 16'd0);
    write_reg(CFG_FRAME_LENGTH, 16'd5);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_check_frame(5, 1'b0, -1, -1);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering bytes,
  // so the core must fill and drop item.ready
  task automatic test_output_backpressure();
    write_reg(CFG_SEND_MODE, 16'd1);
    write_reg(CFG_FRAME_LENGTH, 16'd8);
    write_reg(CFG_CRC_SEED, 16'($urandom_range(0, 65535)));
    steady    = 1'b1;
    hold_left = 80;
    repeat (4) send_payload(6);
    steady = 1'b0;
  endtask

  // Random phases: fresh settings each phase, mostly well-formed frames with
  // random content, the rest corrupted, cut short, noise or aborted midway.
  // The second phase runs the longest frame with no idling on either side.
  task automatic test_random_frames();
    int start, phase, fl, eff, frames, kind, r, k, n;
    logic [15:0] seed;
    bit big_done;
    start    = n_items;
    phase    = 0;
    big_done = 1'b0;
    while (n_items - start < RANDOM_ITEMS) begin
      phase++;
      steady = (phase == 2);
      r = $urandom_range(0, 99);
      if (!big_done && phase == 2) begin
        fl       = 255;
        big_done = 1'b1;
      end else if (r < 10) begin
        fl = $urandom_range(0, 2);
      end else begin
        fl = $urandom_range(3, 12);
      end
      r = $urandom_range(0, 3);
      seed = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      write_reg(CFG_FRAME_LENGTH, 16'(fl));
      write_reg(CFG_SEND_MODE, 16'($urandom_range(0, 1)));
      write_reg(CFG_CRC_SEED, seed);
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
      eff    = (fl < 3) ? 3 : fl;
      frames = (fl == 255) ? 1 : $urandom_range(2, 6);
      repeat (frames) begin
        if (cfg_send) begin
          send_payload(eff - 2);
        end else begin
          kind = (fl == 255) ? 0 : $urandom_range(0, 99);
          if (kind < 55)
            send_check_frame(eff, 1'b0, -1, -1);
          else if (kind < 65)
            send_check_frame(eff, 1'b1, -1, -1);
          else if (kind < 75)
            send_check_frame(eff, 1'b0, $urandom_range(1, eff - 1), -1);
          else if (kind < 85)
            send_check_frame(eff, 1'($urandom_range(0, 1)), -1,
                             $urandom_range(0, eff - 2));
          else begin
            // Noise; the closing marker brings the frame back in step
            n = $urandom_range(1, 2 * eff);
            for (k = 0; k < n; k++)
              send_byte(8'($urandom_range(0, 255)),
                        (k == n - 1) || ($urandom_range(0, 9) == 0));
          end
        end
      end
      // Sometimes leave a frame half done for the next write to abort
      if ($urandom_range(0, 3) == 0) begin
        if (!cfg_send)
          for (k = $urandom_range(1, eff - 2); k > 0; k--)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        else if (eff > 3)
          send_payload($urandom_range(1, eff - 3));
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, a no-idle stretch, and the long hold when asked
  // ---------------------------------------------------------------------------
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Compare every result transaction with the oldest owed result
  always @(posedge clk) begin
    result_t want;
    logic    bad;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (res_ch.is_status) n_status++;
      if (due_outputs.size() == 0) begin
        $error("unexpected result: out_byte %0h is_status %0b status %0d crc %0h last %0b",
               res_ch.out_byte, res_ch.is_status, res_ch.frame_status, res_ch.crc_value,
               res_ch.last);
        n_fail++;
      end else begin
        want = due_outputs.pop_front();
        bad  = 1'b0;
        if (res_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, res_ch.out_byte);
          bad = 1'b1;
        end
        if (res_ch.is_status !== want.is_status) begin
          $error("is_status: expected %0b, got %0b", want.is_status, res_ch.is_status);
          bad = 1'b1;
        end
        if (res_ch.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status,
                 res_ch.frame_status);
          bad = 1'b1;
        end
        if (res_ch.crc_value !== want.crc_value) begin
          $error("crc_value: expected %0h, got %0h", want.crc_value, res_ch.crc_value);
          bad = 1'b1;
        end
        if (res_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_ch.last);
          bad = 1'b1;
        end
        if (bad) n_fail++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               due_outputs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    n_fail       = 0;
    n_items      = 0;
    n_results    = 0;
    n_status     = 0;
    n_cfg_writes = 0;
    cycles       = 0;
    hold_left    = 0;
    steady       = 1'b0;

    // Drive every input from time zero, with reset held at first
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= CFG_FRAME_LENGTH;
    cfg_data          <= 16'h0000;
    item_ch.valid     <= 1'b0;
    item_ch.data_byte <= 8'h00;
    item_ch.frame_end <= 1'b0;

    cfg_len  = FRAME_LENGTH_RST;
    cfg_send = 1'b0;
    cfg_seed = CRC_SEED_RST;
    restart_frame();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_min_length_status();
    test_seed_extremes();
    test_append_mode();
    test_config_abort();
    test_output_backpressure();
    test_random_frames();

    // Drain: wait out owed results, then keep clocking for stray output
    item_ch.valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d byte transactions, %0d results (%0d frame statuses)",
             n_items, n_results, n_status);
    $display("across %0d register writes in check and append modes, %0d mismatches",
             n_cfg_writes, n_fail);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
